// ===== hdl/sha3rp_pkg.sv =====
`timescale 1ns / 1ps

package sha3rp_pkg;

	localparam int unsigned WordBits  = 32;
	localparam int unsigned NumRounds = 3;
	localparam int unsigned RoundBits = 2;

	typedef logic [WordBits-1:0]  word_t;
	typedef logic [RoundBits-1:0] round_idx_t;

	// Round constants K[0..2]
	localparam word_t RoundK0 = 32'h428a2f98;
	localparam word_t RoundK1 = 32'h71374491;
	localparam word_t RoundK2 = 32'hb5c0fbcf;

	// Everything that travels down the chain of round cells
	typedef struct packed {
		word_t [7:0]           v;      // working values, v[0] = a .. v[7] = h
		word_t [NumRounds-1:0] w;      // message words for rounds 0..2
		word_t [NumRounds-1:0] new_a;  // a after each round
		word_t [NumRounds-1:0] new_e;  // e after each round
	} item_t;

	function automatic word_t round_k(input round_idx_t r);
		word_t k;
		unique case (r)
			round_idx_t'(0): k = RoundK0;
			round_idx_t'(1): k = RoundK1;
			round_idx_t'(2): k = RoundK2;
			default:         k = '0;
		endcase
		return k;
	endfunction

	// Sigma1: rotate right by 6, 11, 25
	function automatic word_t big_sigma1(input word_t e);
		return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
	endfunction

	// Sigma0: rotate right by 2, 13, 22
	function automatic word_t big_sigma0(input word_t a);
		return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return g ^ (e & (f ^ g));
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		return (a & b) | (c & (a | b));
	endfunction

endpackage

// ===== hdl/sha256_three_round_precalc.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// -------  ---------------------  ---------------------------------------------
// in       in_valid / in_stall    mid_a..mid_h, msg_word0..msg_word2
// out      out_valid / out_stall  a_after_round0..2, e_after_round0..2
//
// Three round cells in a chain, one SHA-256 round per cell, one item per cycle
// while in_stall is low. An accepted item goes through the three cell registers
// in order; the last cell is the output register. Reset clears the valid flags
// only. An output stall passes back through full cells and stops at an empty one,
// so in_stall rises only when all three cells hold items and out_stall is high.

module sha256_three_round_precalc import sha3rp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  word_t mid_a,
	input  word_t mid_b,
	input  word_t mid_c,
	input  word_t mid_d,
	input  word_t mid_e,
	input  word_t mid_f,
	input  word_t mid_g,
	input  word_t mid_h,
	input  word_t msg_word0,
	input  word_t msg_word1,
	input  word_t msg_word2,
	output logic  out_valid,
	input  logic  out_stall,
	output word_t a_after_round0,
	output word_t a_after_round1,
	output word_t a_after_round2,
	output word_t e_after_round0,
	output word_t e_after_round1,
	output word_t e_after_round2
);

	logic  [NumRounds:0] link_valid;
	logic  [NumRounds:0] link_stall;
	item_t [NumRounds:0] link_item;
	item_t               in_item;

	// Pack the input transaction
	always_comb begin
		in_item       = '0;
		in_item.v[0]  = mid_a;
		in_item.v[1]  = mid_b;
		in_item.v[2]  = mid_c;
		in_item.v[3]  = mid_d;
		in_item.v[4]  = mid_e;
		in_item.v[5]  = mid_f;
		in_item.v[6]  = mid_g;
		in_item.v[7]  = mid_h;
		in_item.w[0]  = msg_word0;
		in_item.w[1]  = msg_word1;
		in_item.w[2]  = msg_word2;
	end
	assign link_item[0]  = in_item;
	assign link_valid[0] = in_valid;
	assign in_stall      = link_stall[0];

	// Chain of round cells
	for (genvar r = 0; r < NumRounds; r++) begin : g_cell
		sha3rp_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.round_idx (round_idx_t'(r)),
			.up_valid  (link_valid[r]),
			.up_item   (link_item[r]),
			.up_stall  (link_stall[r]),
			.dn_valid  (link_valid[r+1]),
			.dn_item   (link_item[r+1]),
			.dn_stall  (link_stall[r+1])
		);
	end

	// Drive the output transaction from the last cell
	assign link_stall[NumRounds] = out_stall;
	assign out_valid      = link_valid[NumRounds];
	assign a_after_round0 = link_item[NumRounds].new_a[0];
	assign a_after_round1 = link_item[NumRounds].new_a[1];
	assign a_after_round2 = link_item[NumRounds].new_a[2];
	assign e_after_round0 = link_item[NumRounds].new_e[0];
	assign e_after_round1 = link_item[NumRounds].new_e[1];
	assign e_after_round2 = link_item[NumRounds].new_e[2];

	// An accepted transaction reaches the output if out_stall stays low on its way
	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("accepted transaction did not reach the output");

	// Input stalls only when the whole chain is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (link_valid[1] && link_valid[2] && out_valid && out_stall))
		else $error("input stalled while the chain had room");

	// A drained chain with nothing upstream empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !link_valid[2]) |=> !out_valid)
		else $error("output valid without a transaction behind it");

endmodule

// ===== hdl/sha3rp_round_cell.sv =====
`timescale 1ns / 1ps

module sha3rp_round_cell import sha3rp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  round_idx_t round_idx,
	input  logic       up_valid,
	input  item_t      up_item,
	output logic       up_stall,
	output logic       dn_valid,
	output item_t      dn_item,
	input  logic       dn_stall
);

	logic  valid_q;
	item_t item_q;
	logic  advance;
	item_t next_item;
	word_t t1;
	word_t t2;

	// Take a new transaction when empty or when the held one moves on
	assign advance  = !valid_q || !dn_stall;
	assign up_stall = !advance;

	// One compression round on the incoming item
	always_comb begin
		t1 = up_item.v[7] + big_sigma1(up_item.v[4])
			+ choose(up_item.v[4], up_item.v[5], up_item.v[6])
			+ round_k(round_idx) + up_item.w[round_idx];
		t2 = big_sigma0(up_item.v[0])
			+ majority(up_item.v[0], up_item.v[1], up_item.v[2]);
		next_item      = up_item;
		next_item.v[7] = up_item.v[6];
		next_item.v[6] = up_item.v[5];
		next_item.v[5] = up_item.v[4];
		next_item.v[4] = up_item.v[3] + t1;
		next_item.v[3] = up_item.v[2];
		next_item.v[2] = up_item.v[1];
		next_item.v[1] = up_item.v[0];
		next_item.v[0] = t1 + t2;
		next_item.new_a[round_idx] = t1 + t2;
		next_item.new_e[round_idx] = up_item.v[3] + t1;
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up_valid;
		end
	end

	// Load the payload on every accepted transaction
	always_ff @(posedge clk) begin
		if (advance && up_valid) begin
			item_q <= next_item;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb import sha3rp_pkg::*; ();

	localparam int unsigned RandomJobs  = 1800;
	localparam int unsigned MaxWait     = 17;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned DrainCycles = 8;
	localparam int unsigned BurstFirst  = 380;
	localparam int unsigned BurstLast   = 800;
	localparam int unsigned HoldAt      = 420;
	localparam int unsigned HoldCycles  = 200;
	localparam int unsigned NumDirected = 18;

	localparam word_t Zeros = 32'h00000000;
	localparam word_t Ones  = 32'hffffffff;

	localparam word_t RoundConst [3] = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf};

	// midstate a..h in mid[0..7], message words for rounds 0..2 in msg[0..2]
	typedef struct packed {
		word_t [7:0] mid;
		word_t [2:0] msg;
	} job_t;

	typedef struct packed {
		word_t [2:0] a;
		word_t [2:0] e;
	} rounds_t;

	// Columns: mid_a .. mid_h, msg_word0 .. msg_word2
	localparam word_t DirectedRows [NumDirected][11] = '{
		// all clear, all set
		'{Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros},
		'{Ones, Ones, Ones, Ones, Ones, Ones, Ones, Ones, Ones, Ones, Ones},
		// alternating bits
		'{32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa,
			32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'h55555555,
			32'h55555555},
		'{32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
			32'h55555555, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa,
			32'haaaaaaaa},
		// standard initial hash value as midstate
		'{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a, 32'h510e527f,
			32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19, Zeros, Zeros, Zeros},
		'{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a, 32'h510e527f,
			32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19, Ones, Ones, Ones},
		// halves of the working set
		'{Ones, Ones, Ones, Ones, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros},
		'{Zeros, Zeros, Zeros, Zeros, Ones, Ones, Ones, Ones, Ones, Ones, Ones},
		// choose takes f, then g
		'{Zeros, Zeros, Zeros, Zeros, Ones, Ones, Zeros, Zeros, Zeros, Zeros, Zeros},
		'{Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Ones, Zeros, Zeros, Zeros, Zeros},
		// majority with two set, one set
		'{Ones, Ones, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros},
		'{Ones, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros},
		// lone top bit, lone bottom bit
		'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000},
		'{32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001,
			32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001,
			32'h00000001},
		// long carry chains through the additions
		'{Zeros, Zeros, Zeros, Ones, Zeros, Zeros, Zeros, Ones, Ones, Ones, Ones},
		// one message word at a time
		'{Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Ones, Zeros},
		'{Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Zeros, Ones},
		// distinct bytes everywhere, catches swapped byte order
		'{32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, 32'h0f1e2d3c,
			32'h4b5a6978, 32'h8796a5b4, 32'hc3d2e1f0, 32'hdeadbeef, 32'h00ff00ff,
			32'hff00ff00}
	};

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	logic  out_valid;
	logic  out_stall;
	word_t mid_a, mid_b, mid_c, mid_d, mid_e, mid_f, mid_g, mid_h;
	word_t msg_word0, msg_word1, msg_word2;
	word_t a_after_round0, a_after_round1, a_after_round2;
	word_t e_after_round0, e_after_round1, e_after_round2;

	rounds_t     expected_rounds_q [$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	sha256_three_round_precalc u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mid_a          (mid_a),
		.mid_b          (mid_b),
		.mid_c          (mid_c),
		.mid_d          (mid_d),
		.mid_e          (mid_e),
		.mid_f          (mid_f),
		.mid_g          (mid_g),
		.mid_h          (mid_h),
		.msg_word0      (msg_word0),
		.msg_word1      (msg_word1),
		.msg_word2      (msg_word2),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.a_after_round0 (a_after_round0),
		.a_after_round1 (a_after_round1),
		.a_after_round2 (a_after_round2),
		.e_after_round0 (e_after_round0),
		.e_after_round1 (e_after_round1),
		.e_after_round2 (e_after_round2)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic word_t rotl(word_t x, int unsigned n);
		return (x << n) | (x >> (WordBits - n));
	endfunction

	// Run compression rounds 0..2 and collect a and e after each
	function automatic rounds_t run_three_rounds(job_t j);
		word_t   v [8];
		word_t   s0, s1, ch, mj, t1, t2;
		rounds_t r;
		for (int k = 0; k < 8; k++) v[k] = j.mid[k];
		for (int n = 0; n < 3; n++) begin
			s1 = rotl(v[4], 26) ^ rotl(v[4], 21) ^ rotl(v[4], 7);
			ch = (v[4] & v[5]) | (~v[4] & v[6]);
			s0 = rotl(v[0], 30) ^ rotl(v[0], 19) ^ rotl(v[0], 10);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + s1 + ch + RoundConst[n] + j.msg[n];
			t2 = s0 + mj;
			for (int k = 7; k > 0; k--) v[k] = v[k-1];
			// v[4] now holds the old d
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
			r.a[n] = v[0];
			r.e[n] = v[4];
		end
		return r;
	endfunction

	// Bias toward edge values now and then, mostly full random
	function automatic word_t pick_word();
		unique case ($urandom_range(9, 0))
			0: begin
				return Zeros;
			end
			1: begin
				return Ones;
			end
			2: begin
				return word_t'(1) << $urandom_range(31, 0);
			end
			3: begin
				return ~(word_t'(1) << $urandom_range(31, 0));
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic job_t random_job();
		job_t j;
		for (int k = 0; k < 8; k++) j.mid[k] = pick_word();
		for (int k = 0; k < 3; k++) j.msg[k] = pick_word();
		return j;
	endfunction

	// Idle cycles before the next transaction; one window in four runs flat out
	function automatic int unsigned draw_wait(int unsigned idx, int unsigned quiet_phase);
		if ((idx / 200) % 4 == quiet_phase) begin
			return 0;
		end
		if ($urandom_range(1, 0) == 0) begin
			return 0;
		end
		return $urandom_range(MaxWait, 0);
	endfunction

	function automatic void check_word(string name, word_t want, word_t got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic drive_payload(job_t j);
		mid_a     <= j.mid[0];
		mid_b     <= j.mid[1];
		mid_c     <= j.mid[2];
		mid_d     <= j.mid[3];
		mid_e     <= j.mid[4];
		mid_f     <= j.mid[5];
		mid_g     <= j.mid[6];
		mid_h     <= j.mid[7];
		msg_word0 <= j.msg[0];
		msg_word1 <= j.msg[1];
		msg_word2 <= j.msg[2];
	endtask

	// Idle with junk on the bus, then offer and hold until accepted
	task automatic offer_job(job_t j, int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			drive_payload(random_job());
			repeat (gap) @(posedge clk);
		end
		drive_payload(j);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_rounds_q.push_back(run_three_rounds(j));
	endtask

	initial begin : stimulus
		job_t        j;
		int unsigned job_idx;
		int unsigned gap;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		drive_payload('0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		job_idx = 0;

		// directed rows
		for (int r = 0; r < NumDirected; r++) begin
			for (int k = 0; k < 8; k++) j.mid[k] = DirectedRows[r][k];
			for (int k = 0; k < 3; k++) j.msg[k] = DirectedRows[r][8 + k];
			offer_job(j, draw_wait(job_idx, 1));
			job_idx++;
		end

		// random items; keep offering back to back across the receiver's long hold
		repeat (RandomJobs) begin
			if (job_idx >= BurstFirst && job_idx < BurstLast) begin
				gap = 0;
			end else begin
				gap = draw_wait(job_idx, 1);
			end
			offer_job(random_job(), gap);
			job_idx++;
		end
		in_valid <= 1'b0;

		// drain
		while (expected_rounds_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Stall the output at random, with one long hold to back the pipe up
	initial begin : receiver
		int unsigned taken;
		int unsigned wait_n;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (taken == HoldAt) begin
				wait_n = HoldCycles;
			end else begin
				wait_n = draw_wait(taken, 2);
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Compare each accepted result with the oldest pending expectation
	always @(posedge clk) begin
		rounds_t want;
		if (out_valid && !out_stall) begin
			if (expected_rounds_q.size() == 0) begin
				$error("result with no transaction pending");
				mismatches++;
			end else begin
				want = expected_rounds_q.pop_front();
				check_word("a_after_round0", want.a[0], a_after_round0);
				check_word("a_after_round1", want.a[1], a_after_round1);
				check_word("a_after_round2", want.a[2], a_after_round2);
				check_word("e_after_round0", want.e[0], e_after_round0);
				check_word("e_after_round1", want.e[1], e_after_round1);
				check_word("e_after_round2", want.e[2], e_after_round2);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

endmodule

// ===== sha256_three_round_precalc.f =====
hdl/sha3rp_pkg.sv
hdl/sha3rp_round_cell.sv
hdl/sha256_three_round_precalc.sv
verif/tb.sv
